// File: rtl/ome_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ome_pkg: shared types, constants and the E24 table
// Widths of the reading path, configuration layout and the table lookup that
// turns a walk index into a nominal value with its color bands.
// ----------------------------------------------------------------------------
package ome_pkg;

    localparam int MAX_SAMPLES  = 1024;
    localparam int ADC_BITS     = 12;
    localparam int COUNT_W      = 11;
    localparam int SUM_W        = 22;
    localparam int KNOWN_W      = 16;
    localparam int TOL_W        = 5;
    localparam int FS_W         = 12;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 16;
    localparam int OHMS_W       = 17;
    localparam int DIGIT_W      = 4;
    localparam int EXP_W        = 3;

    // Derived datapath widths.
    localparam int FULL_W       = COUNT_W + FS_W;          // count * full scale
    localparam int K100_W       = KNOWN_W + 7;             // 100 * known
    localparam int NUM_W        = K100_W + SUM_W;          // 100 * known * sum
    localparam int LO_W         = 7;                       // 100 - tol
    localparam int HI_W         = 8;                       // 100 + tol
    localparam int VLO_W        = OHMS_W + LO_W;
    localparam int VHI_W        = OHMS_W + HI_W;
    localparam int PLO_W        = VLO_W + FULL_W;
    localparam int PHI_W        = VHI_W + FULL_W;

    // Walk over the table: 510..910, then two full decades, then 100000.
    localparam int E24_STEPS    = 56;
    localparam int IDX_W        = 6;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(E24_STEPS - 1);

    localparam int QUEUE_DEPTH  = 2;

    localparam logic [3:0] E24_D1 [0:23] = '{
        4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2, 4'd2, 4'd2, 4'd2, 4'd3,
        4'd3, 4'd3, 4'd3, 4'd4, 4'd4, 4'd5, 4'd5, 4'd6, 4'd6, 4'd7, 4'd8, 4'd9
    };
    localparam logic [3:0] E24_D2 [0:23] = '{
        4'd0, 4'd1, 4'd2, 4'd3, 4'd5, 4'd6, 4'd8, 4'd0, 4'd2, 4'd4, 4'd7, 4'd0,
        4'd3, 4'd6, 4'd9, 4'd3, 4'd7, 4'd1, 4'd6, 4'd2, 4'd8, 4'd5, 4'd2, 4'd1
    };

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KNOWN   = 3'd0,
        CFG_SAMPLES = 3'd1,
        CFG_TOL     = 3'd2,
        CFG_FS      = 3'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [KNOWN_W-1:0] known_resistor;
        logic [COUNT_W-1:0] samples_per_reading;
        logic [TOL_W-1:0]   tolerance_percent;
        logic [FS_W-1:0]    adc_full_scale;
    } cfg_t;

    typedef struct packed {
        logic [SUM_W-1:0]   sum;
        logic [COUNT_W-1:0] count;
    } reading_t;

    typedef struct packed {
        logic valid;
        logic full;
    } queue_stat_t;

    typedef struct packed {
        logic [OHMS_W-1:0]  value;
        logic [DIGIT_W-1:0] d1;
        logic [DIGIT_W-1:0] d2;
        logic [EXP_W-1:0]   exp;
    } e24_t;

    function automatic e24_t ome_e24_entry(input logic [IDX_W-1:0] idx);
        logic [4:0]        k;
        logic [EXP_W-1:0]  e;
        logic [OHMS_W-1:0] scale;
        logic [6:0]        mant;
        e24_t              r;
        if (idx < IDX_W'(7)) begin
            k = 5'(idx + IDX_W'(17));
            e = EXP_W'(1);
            scale = OHMS_W'(10);
        end else if (idx < IDX_W'(31)) begin
            k = 5'(idx - IDX_W'(7));
            e = EXP_W'(2);
            scale = OHMS_W'(100);
        end else if (idx < IDX_W'(55)) begin
            k = 5'(idx - IDX_W'(31));
            e = EXP_W'(3);
            scale = OHMS_W'(1000);
        end else begin
            k = 5'd0;
            e = EXP_W'(4);
            scale = OHMS_W'(10000);
        end
        mant = 7'(E24_D1[k]) * 7'd10 + 7'(E24_D2[k]);
        r.value = OHMS_W'(mant) * scale;
        r.d1 = E24_D1[k];
        r.d2 = E24_D2[k];
        r.exp = e;
        return r;
    endfunction

endpackage

// File: rtl/ome_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ome_front: sample accumulator
// Sums samples and hands a finished sum and count to the reading queue.
// ----------------------------------------------------------------------------
module ome_front (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  ome_pkg::cfg_t                cfg,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [ome_pkg::ADC_BITS-1:0] s_adc_sample,
    input  ome_pkg::queue_stat_t         q_stat,
    output logic                         q_push,
    output ome_pkg::reading_t            q_data
);
    import ome_pkg::*;

    logic [SUM_W-1:0]   sum_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [SUM_W-1:0]   sum_next;
    logic [COUNT_W-1:0] count_next;
    logic [COUNT_W-1:0] target;
    logic               accept;
    logic               last;

    // Zero means one sample; anything above the limit saturates.
    always_comb begin
        if (cfg.samples_per_reading == '0) begin
            target = COUNT_W'(1);
        end else if (cfg.samples_per_reading > COUNT_W'(MAX_SAMPLES)) begin
            target = COUNT_W'(MAX_SAMPLES);
        end else begin
            target = cfg.samples_per_reading;
        end
    end

    assign s_ready    = !q_stat.full;
    assign accept     = s_valid && s_ready;
    assign sum_next   = sum_reg + SUM_W'(s_adc_sample);
    assign count_next = count_reg + COUNT_W'(1);
    assign last       = count_next >= target;

    assign q_push       = accept && last;
    assign q_data.sum   = sum_next;
    assign q_data.count = count_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg   <= '0;
            count_reg <= '0;
        end else if (accept) begin
            if (last) begin
                sum_reg   <= '0;
                count_reg <= '0;
            end else begin
                sum_reg   <= sum_next;
                count_reg <= count_next;
            end
        end
    end

endmodule

// File: rtl/ome_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ome_queue: reading queue
// Short first-in first-out queue of finished sums between accumulator and
// matcher.
// ----------------------------------------------------------------------------
module ome_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  ome_pkg::reading_t    push_data,
    input  logic                 pop,
    output ome_pkg::reading_t    pop_data,
    output ome_pkg::queue_stat_t stat
);
    import ome_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    reading_t           mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W:0]     fill_reg;

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : PTR_W'(p + PTR_W'(1));
    endfunction

    assign stat.valid = fill_reg != '0;
    assign stat.full  = fill_reg == (PTR_W + 1)'(QUEUE_DEPTH);
    assign pop_data   = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= bump(wr_ptr_reg);
            end
            if (pop) begin
                rd_ptr_reg <= bump(rd_ptr_reg);
            end
            if (push && !pop) begin
                fill_reg <= fill_reg + (PTR_W + 1)'(1);
            end else if (pop && !push) begin
                fill_reg <= fill_reg - (PTR_W + 1)'(1);
            end
        end
    end

endmodule

// File: rtl/ome_match.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ome_match: resistance computation and E24 match
// Forms the cross-multiplied window test and walks the E24 table through a
// three-stage pipeline; the first hit in table order ends the walk.
// ----------------------------------------------------------------------------
module ome_match (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  ome_pkg::cfg_t               cfg,
    input  ome_pkg::queue_stat_t        q_stat,
    input  ome_pkg::reading_t           q_data,
    output logic                        q_pop,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_matched,
    output logic [ome_pkg::OHMS_W-1:0]  m_nominal_ohms,
    output logic [ome_pkg::DIGIT_W-1:0] m_first_digit,
    output logic [ome_pkg::DIGIT_W-1:0] m_second_digit,
    output logic [ome_pkg::EXP_W-1:0]   m_multiplier_exp
);
    import ome_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL1,
        ST_MUL2,
        ST_WALK,
        ST_DONE
    } state_t;

    state_t             state_reg;
    logic [SUM_W-1:0]   sum_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [FULL_W-1:0]  full_reg;
    logic [K100_W-1:0]  k100_reg;
    logic [FULL_W-1:0]  den_reg;
    logic               den_ok_reg;
    logic [NUM_W-1:0]   num_reg;
    logic [LO_W-1:0]    lo_reg;
    logic [HI_W-1:0]    hi_reg;

    logic [IDX_W-1:0]   issue_idx_reg;
    logic               issue_on_reg;
    logic               s1_valid_reg;
    logic [IDX_W-1:0]   s1_idx_reg;
    logic [VLO_W-1:0]   vlo_reg;
    logic [VHI_W-1:0]   vhi_reg;
    logic               s2_valid_reg;
    logic [IDX_W-1:0]   s2_idx_reg;
    logic [PLO_W-1:0]   plo_reg;
    logic [PHI_W-1:0]   phi_reg;

    logic               hit_reg;
    logic [IDX_W-1:0]   hit_idx_reg;

    logic               out_valid_reg;
    logic               matched_reg;
    logic [OHMS_W-1:0]  nominal_reg;
    logic [DIGIT_W-1:0] first_digit_reg;
    logic [DIGIT_W-1:0] second_digit_reg;
    logic [EXP_W-1:0]   multiplier_exp_reg;

    e24_t               ent_issue;
    e24_t               ent_hit;
    logic               in_window;
    logic               slot_free;

    assign ent_issue = ome_e24_entry(issue_idx_reg);
    assign ent_hit   = ome_e24_entry(hit_idx_reg);
    assign in_window = (PHI_W'(plo_reg) <= PHI_W'(num_reg)) &&
                       (PHI_W'(num_reg) <= phi_reg);
    assign slot_free = !out_valid_reg || m_ready;
    assign q_pop     = (state_reg == ST_IDLE) && q_stat.valid;

    assign m_valid          = out_valid_reg;
    assign m_matched        = matched_reg;
    assign m_nominal_ohms   = nominal_reg;
    assign m_first_digit    = first_digit_reg;
    assign m_second_digit   = second_digit_reg;
    assign m_multiplier_exp = multiplier_exp_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            issue_on_reg  <= 1'b0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            hit_reg       <= 1'b0;
        end else begin
            // A result taken while a new one is being loaded is replaced below.
            if (out_valid_reg && m_ready && (state_reg != ST_DONE)) begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (q_stat.valid) begin
                        sum_reg   <= q_data.sum;
                        count_reg <= q_data.count;
                        state_reg <= ST_MUL1;
                    end
                end
                ST_MUL1: begin
                    full_reg  <= FULL_W'(count_reg) * FULL_W'(cfg.adc_full_scale);
                    k100_reg  <= K100_W'(cfg.known_resistor) * K100_W'(100);
                    lo_reg    <= LO_W'(100) - LO_W'(cfg.tolerance_percent);
                    hi_reg    <= HI_W'(100) + HI_W'(cfg.tolerance_percent);
                    state_reg <= ST_MUL2;
                end
                ST_MUL2: begin
                    den_reg       <= full_reg - FULL_W'(sum_reg);
                    den_ok_reg    <= full_reg > FULL_W'(sum_reg);
                    num_reg       <= NUM_W'(k100_reg) * NUM_W'(sum_reg);
                    issue_idx_reg <= '0;
                    issue_on_reg  <= 1'b1;
                    s1_valid_reg  <= 1'b0;
                    s2_valid_reg  <= 1'b0;
                    hit_reg       <= 1'b0;
                    if (full_reg > FULL_W'(sum_reg)) begin
                        state_reg <= ST_WALK;
                    end else begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_WALK: begin
                    // Stage 0: scale the table value by both window percentages.
                    s1_valid_reg <= issue_on_reg;
                    s1_idx_reg   <= issue_idx_reg;
                    vlo_reg      <= VLO_W'(ent_issue.value) * VLO_W'(lo_reg);
                    vhi_reg      <= VHI_W'(ent_issue.value) * VHI_W'(hi_reg);
                    if (issue_on_reg) begin
                        issue_idx_reg <= IDX_W'(issue_idx_reg + IDX_W'(1));
                        if (issue_idx_reg == IDX_LAST) begin
                            issue_on_reg <= 1'b0;
                        end
                    end
                    // Stage 1: bring the bounds to the numerator's scale.
                    s2_valid_reg <= s1_valid_reg;
                    s2_idx_reg   <= s1_idx_reg;
                    plo_reg      <= PLO_W'(vlo_reg) * PLO_W'(den_reg);
                    phi_reg      <= PHI_W'(vhi_reg) * PHI_W'(den_reg);
                    // Stage 2: window test; entries arrive in table order.
                    if (s2_valid_reg) begin
                        if (in_window) begin
                            hit_reg      <= 1'b1;
                            hit_idx_reg  <= s2_idx_reg;
                            state_reg    <= ST_DONE;
                        end else if (s2_idx_reg == IDX_LAST) begin
                            state_reg <= ST_DONE;
                        end
                    end
                end
                ST_DONE: begin
                    s1_valid_reg <= 1'b0;
                    s2_valid_reg <= 1'b0;
                    if (slot_free) begin
                        out_valid_reg      <= 1'b1;
                        matched_reg        <= hit_reg;
                        nominal_reg        <= hit_reg ? ent_hit.value : '0;
                        first_digit_reg    <= hit_reg ? ent_hit.d1 : '0;
                        second_digit_reg   <= hit_reg ? ent_hit.d2 : '0;
                        multiplier_exp_reg <= hit_reg ? ent_hit.exp : '0;
                        state_reg          <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    a_walk_needs_den: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_WALK |-> den_ok_reg)
        else $error("table walk started with a non-positive denominator");

    a_walk_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WALK) && s1_valid_reg && s2_valid_reg
        |-> s1_idx_reg == IDX_W'(s2_idx_reg + IDX_W'(1)))
        else $error("table entries out of order in the walk pipeline");

    a_hold_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE) && out_valid_reg && !m_ready |=> state_reg == ST_DONE)
        else $error("finished reading dropped while the output was stalled");

    a_match_bands: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && matched_reg
        |-> (multiplier_exp_reg != '0) && (first_digit_reg != '0))
        else $error("matched result carries empty color bands");

endmodule

// File: rtl/ohmmeter_e24_match_color_code_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ohmmeter_e24_match_color_code_unit: divider ohmmeter with E24 snap
// Averages ADC samples of a divider, solves for the unknown resistor and
// reports the first E24 value within tolerance with its color bands.
// ----------------------------------------------------------------------------
// Throughput: one sample per cycle while the two-entry reading queue is not
// full; the sample that completes a reading enters that queue.
// The result follows the final sample through two multiply steps and the
// pipelined walk over 56 table entries (three stages, one entry a cycle).
// Reset (aresetn low, synchronous) clears the sum, count, queue and matcher
// and restores the configuration defaults 9870 ohm, 500 samples, 5 %, 4095.
module ohmmeter_e24_match_color_code_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Configuration write port.
    input  logic                          cfg_we,
    input  logic [ome_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ome_pkg::CFG_DATA_W-1:0] cfg_wdata,
    // Sample requests.
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [ome_pkg::ADC_BITS-1:0]  s_adc_sample,
    // Result requests.
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_matched,
    output logic [ome_pkg::OHMS_W-1:0]    m_nominal_ohms,
    output logic [ome_pkg::DIGIT_W-1:0]   m_first_digit,
    output logic [ome_pkg::DIGIT_W-1:0]   m_second_digit,
    output logic [ome_pkg::EXP_W-1:0]     m_multiplier_exp
);
    import ome_pkg::*;

    cfg_t        cfg_reg;
    logic        q_push;
    logic        q_pop;
    reading_t    q_in;
    reading_t    q_out;
    queue_stat_t q_stat;

    // Configuration registers. Writes to indexes past the last register are
    // dropped. Each register keeps only the low bits of the write data.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.known_resistor      <= KNOWN_W'(9870);
            cfg_reg.samples_per_reading <= COUNT_W'(500);
            cfg_reg.tolerance_percent   <= TOL_W'(5);
            cfg_reg.adc_full_scale      <= FS_W'(4095);
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_KNOWN:   cfg_reg.known_resistor      <= cfg_wdata[KNOWN_W-1:0];
                CFG_SAMPLES: cfg_reg.samples_per_reading <= cfg_wdata[COUNT_W-1:0];
                CFG_TOL:     cfg_reg.tolerance_percent   <= cfg_wdata[TOL_W-1:0];
                CFG_FS:      cfg_reg.adc_full_scale      <= cfg_wdata[FS_W-1:0];
                default:     ;
            endcase
        end
    end

    // Front end: every accepted sample is added to the registered sum. The sample
    // that completes a reading pushes the sum and count to the queue and
    // clears the accumulator for the next reading.
    ome_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg_reg),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_adc_sample (s_adc_sample),
        .q_stat       (q_stat),
        .q_push       (q_push),
        .q_data       (q_in)
    );

    // The queue lets sampling continue while the matcher is busy with an
    // earlier reading or waiting on a stalled result.
    ome_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .pop_data  (q_out),
        .stat      (q_stat)
    );

    // Back end: forms the denominator and numerator in two multiply steps,
    // then tests each E24 value against the window
    //   V*(100-tol)*den <= 100*known*sum <= V*(100+tol)*den
    // in ascending order. A non-positive denominator or no hit reports an
    // all-zero result. The result sits in an output register until taken.
    ome_match u_match (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg              (cfg_reg),
        .q_stat           (q_stat),
        .q_data           (q_out),
        .q_pop            (q_pop),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_matched        (m_matched),
        .m_nominal_ohms   (m_nominal_ohms),
        .m_first_digit    (m_first_digit),
        .m_second_digit   (m_second_digit),
        .m_multiplier_exp (m_multiplier_exp)
    );

endmodule
